// ----- hw/rtl/isort_pkg.sv -----
// Shared types for the insertion sorter cell chain.
package isort_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] value_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic load;   // insert new_value this cycle
        logic drain;  // shift the chain one cell toward the output
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/isort_cell.sv -----
// One cell of the insertion chain: holds one sorted entry and its valid bit.
module isort_cell
    import isort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     new_value,
    input  value_t     left_data,
    input  logic       left_valid,
    input  logic       left_gt,
    input  value_t     right_data,
    input  logic       right_valid,
    output value_t     data,
    output logic       valid,
    output logic       gt
);

    value_t data_reg;
    value_t data_next;
    logic   valid_reg;
    logic   valid_next;

    // held entry is strictly greater: it moves right, new value lands left of it
    assign gt    = valid_reg && (data_reg > new_value);
    assign data  = data_reg;
    assign valid = valid_reg;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        priority if (ctrl.drain)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.load)
        begin
            priority if (left_gt)
            begin
                data_next  = left_data;
                valid_next = 1'b1;
            end
            else if (gt || (!valid_reg && left_valid))
            begin
                data_next  = new_value;
                valid_next = 1'b1;
            end
            else
            begin
                // entry left of the insertion point, or an empty cell past it: keep it
                valid_next = valid_reg;
            end
        end
        else
        begin
            // idle: hold
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- hw/rtl/insertion_sorter_core.sv -----
// Top level of the streaming insertion sorter built from a chain of cells.
//
// Usage:
//   Input beats: drive value and final_item with start high; the beat is taken
//   at a rising edge where busy is low. While loading, one beat is taken every
//   cycle: each beat is compared against all cells at once and the chain
//   shifts right of the insertion point in that same cycle.
//   A beat with final_item high closes the set. Its value is inserted (or
//   dropped if the chain is full), then busy rises and the chain drains from
//   cell 0, one result per cycle, for each of the N held entries
//   (N is 1..CAPACITY). result_valid marks each result for one cycle;
//   end_of_set marks the last. The first result appears the cycle after the
//   final beat; busy stays high through the last result and falls at the edge
//   that takes it, so the next set may start in the cycle after it.
//   The drain rate is set by the one-entry-per-cycle left shift of the chain,
//   and no new beat is taken until the drain of the set has ended.
//   Values arriving while all CAPACITY cells are full are dropped; overflow
//   is then high on every result of that set.
//   Reset clears every cell's valid bit and the control flags; the chain is
//   empty and ready at once. The receiver cannot stall: results are never held.
module insertion_sorter_core
    import isort_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     final_item,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     end_of_set,
    output logic                     overflow
);

    value_t        cell_data  [CAPACITY];
    logic          cell_valid [CAPACITY];
    logic          cell_gt    [CAPACITY];
    cell_ctrl_t    ctrl;

    logic draining_reg;
    logic draining_next;
    logic dropped_reg;
    logic dropped_next;
    logic accept;
    logic full;

    assign accept = start && !busy;
    // last cell valid means every cell holds an entry
    assign full   = cell_valid[CAPACITY-1];

    assign ctrl.load  = accept && !full;
    assign ctrl.drain = draining_reg;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            value_t left_data;
            logic   left_valid;
            logic   left_gt;
            value_t right_data;
            logic   right_valid;

            if (i == 0)
            begin : g_head
                // head of the chain: always a legal landing spot
                assign left_data  = value;
                assign left_valid = 1'b1;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_body
                assign left_data  = cell_data[i-1];
                assign left_valid = cell_valid[i-1];
                assign left_gt    = cell_gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_data  = value;
                assign right_valid = 1'b0;
            end
            else
            begin : g_inner
                assign right_data  = cell_data[i+1];
                assign right_valid = cell_valid[i+1];
            end

            isort_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_value   (value),
                .left_data   (left_data),
                .left_valid  (left_valid),
                .left_gt     (left_gt),
                .right_data  (right_data),
                .right_valid (right_valid),
                .data        (cell_data[i]),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    // Set control: drain runs until cell 1 is empty, i.e. cell 0 holds the last entry
    always_comb
    begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        priority if (draining_reg)
        begin
            if (!cell_valid[1])
            begin
                draining_next = 1'b0;
                dropped_next  = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            if (final_item)
            begin
                draining_next = 1'b1;
            end
        end
        else
        begin
            // no beat and no drain: hold
            draining_next = draining_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
        end
    end

    assign busy         = draining_reg;
    assign result_valid = draining_reg && cell_valid[0];
    assign sorted_value = cell_data[0];
    assign end_of_set   = result_valid && !cell_valid[1];
    assign overflow     = dropped_reg;

    // A drain always has an entry in cell 0
    a_busy_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> result_valid)
        else $error("busy without a result in cell 0");

    // Last result of a set frees the block
    a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        end_of_set |=> !busy)
        else $error("still busy after end of set");

    // Results of one set come out in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !end_of_set) |=>
            (result_valid && (sorted_value >= $past(sorted_value))))
        else $error("results out of order");

    // Overflow flag is constant across a set
    a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !end_of_set) |=> (overflow == $past(overflow)))
        else $error("overflow changed within a set");

endmodule
